/* hdl/sil_pkg.sv */
// Shared types and constants for the sorted insert list core.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package sil_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned POS_W       = 5;
   localparam int unsigned FILL_W      = 6;
   localparam int unsigned ADDR_MAX_W  = 5;
   localparam int unsigned MAX_RESULTS = 32;

   localparam logic signed [DATA_W-1:0] END_MARK      = -32'sd1;
   localparam logic        [FILL_W-1:0] CAP_LIMIT_RST = 6'd32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_REJECT
   } sil_state_type;

   // Port of the list store: one write and one registered read per cycle.
   typedef struct packed {
      logic                    we;
      logic [ADDR_MAX_W-1:0]   waddr;
      logic [DATA_W-1:0]       wdata;
      logic                    re;
      logic [ADDR_MAX_W-1:0]   raddr;
   } sil_mem_ctl_type;

endpackage

/* hdl/sil_req_if.sv */
// Input channel of the sorted insert list core: one value per transaction.
// Depends on sil_pkg for the data width.
interface sil_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [sil_pkg::DATA_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

/* hdl/sil_rsp_if.sv */
// Result channel of the sorted insert list core: one list entry per transaction.
// Depends on sil_pkg for the field widths.
interface sil_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [sil_pkg::DATA_W-1:0] element;
   logic        [sil_pkg::POS_W-1:0]  position;
   logic                              last_of_run;
   logic                              rejected;

   modport source (output valid, output element, output position, output last_of_run,
                   output rejected, input ready);
   modport sink   (input valid, input element, input position, input last_of_run,
                   input rejected, output ready);
endinterface

/* hdl/sil_store.sv */
// List storage: a single-port-write, single-port-read memory with registered read data.
// Depends on sil_pkg for the access struct and data width.
module sil_store #(
   parameter int unsigned DEPTH  = 32,
   parameter int unsigned ADDR_W = 5
) (
   input  logic                              clock,
   input  sil_pkg::sil_mem_ctl_type          mem_ctl,
   output logic signed [sil_pkg::DATA_W-1:0] rd_data
);

   logic [sil_pkg::DATA_W-1:0] mem [DEPTH];
   logic [sil_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.we) begin
         mem[mem_ctl.waddr[ADDR_W-1:0]] <= mem_ctl.wdata;
      end
      if (mem_ctl.re) begin
         rd_data_ff <= mem[mem_ctl.raddr[ADDR_W-1:0]];
      end
   end

   assign rd_data = $signed(rd_data_ff);

endmodule

/* hdl/sil_seq.sv */
// Sequencer of the sorted insert list: insertion by repeated compare and shift, then readout.
// Depends on sil_pkg, sil_req_if, sil_rsp_if; drives the port of sil_store.
module sil_seq #(
   parameter int unsigned ADDR_W = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sil_pkg::FILL_W-1:0]        limit,
   sil_req_if.sink                           req,
   sil_rsp_if.source                         rsp,
   output sil_pkg::sil_mem_ctl_type          mem_ctl,
   input  logic signed [sil_pkg::DATA_W-1:0] rd_data
);

   sil_pkg::sil_state_type state_ff, state_in;

   logic signed [sil_pkg::DATA_W-1:0] val_ff, val_in;
   logic [ADDR_W-1:0]                 slot_ff, slot_in;
   logic [ADDR_W-1:0]                 idx_ff, idx_in;
   logic [sil_pkg::FILL_W-1:0]        fill_ff, fill_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [sil_pkg::DATA_W-1:0] element_ff, element_in;
   logic [sil_pkg::POS_W-1:0]         position_ff, position_in;
   logic                              last_ff, last_in;
   logic                              rejected_ff, rejected_in;

   logic accept;
   logic is_end;
   logic is_full;
   logic entry_gt;
   logic is_last;
   logic out_free;
   logic load_elem;
   logic load_rej;

   assign accept   = req.valid && req.ready;
   assign is_end   = (req.value == sil_pkg::END_MARK);
   assign is_full  = (fill_ff >= limit);
   // The shared compare unit: a stored entry moves up while it is greater than the new value.
   assign entry_gt = (rd_data > val_ff);
   assign is_last  = ((sil_pkg::FILL_W'(idx_ff) + sil_pkg::FILL_W'(1)) == fill_ff);
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sil_pkg::ST_IDLE: begin
            if (req.valid && !is_end) begin
               state_in = is_full ? sil_pkg::ST_REJECT : sil_pkg::ST_INS_RD;
            end
         end
         sil_pkg::ST_INS_RD: begin
            state_in = (slot_ff == '0) ? sil_pkg::ST_EMIT_RD : sil_pkg::ST_INS_CMP;
         end
         sil_pkg::ST_INS_CMP: begin
            state_in = entry_gt ? sil_pkg::ST_INS_RD : sil_pkg::ST_EMIT_RD;
         end
         sil_pkg::ST_EMIT_RD: begin
            state_in = sil_pkg::ST_EMIT_LD;
         end
         sil_pkg::ST_EMIT_LD: begin
            if (out_free) begin
               state_in = is_last ? sil_pkg::ST_IDLE : sil_pkg::ST_EMIT_RD;
            end
         end
         sil_pkg::ST_REJECT: begin
            if (out_free) begin
               state_in = sil_pkg::ST_IDLE;
            end
         end
         default: state_in = sil_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake, memory port and output register loads.
   always_comb begin
      req.ready     = 1'b0;
      mem_ctl       = '0;
      load_elem     = 1'b0;
      load_rej      = 1'b0;
      unique case (state_ff)
         sil_pkg::ST_IDLE: begin
            req.ready = 1'b1;
         end
         sil_pkg::ST_INS_RD: begin
            if (slot_ff == '0) begin
               mem_ctl.we    = 1'b1;
               mem_ctl.wdata = val_ff;
            end else begin
               mem_ctl.re    = 1'b1;
               mem_ctl.raddr = sil_pkg::ADDR_MAX_W'(slot_ff - ADDR_W'(1));
            end
         end
         sil_pkg::ST_INS_CMP: begin
            mem_ctl.we    = 1'b1;
            mem_ctl.waddr = sil_pkg::ADDR_MAX_W'(slot_ff);
            mem_ctl.wdata = entry_gt ? rd_data : val_ff;
         end
         sil_pkg::ST_EMIT_RD: begin
            mem_ctl.re    = 1'b1;
            mem_ctl.raddr = sil_pkg::ADDR_MAX_W'(idx_ff);
         end
         sil_pkg::ST_EMIT_LD: begin
            load_elem = out_free;
         end
         sil_pkg::ST_REJECT: begin
            load_rej = out_free;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      val_in  = val_ff;
      slot_in = slot_ff;
      idx_in  = idx_ff;
      fill_in = fill_ff;
      if (accept) begin
         val_in  = req.value;
         slot_in = fill_ff[ADDR_W-1:0];
         idx_in  = '0;
         if (is_end) begin
            fill_in = '0;
         end else if (!is_full) begin
            fill_in = fill_ff + sil_pkg::FILL_W'(1);
         end
      end
      if (state_ff == sil_pkg::ST_INS_CMP && entry_gt) begin
         slot_in = slot_ff - ADDR_W'(1);
      end
      if (load_elem) begin
         idx_in = idx_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      element_in   = element_ff;
      position_in  = position_ff;
      last_in      = last_ff;
      rejected_in  = rejected_ff;
      if (load_elem) begin
         rsp_valid_in = 1'b1;
         element_in   = rd_data;
         position_in  = sil_pkg::POS_W'(idx_ff);
         last_in      = is_last;
         rejected_in  = 1'b0;
      end else if (load_rej) begin
         rsp_valid_in = 1'b1;
         element_in   = val_ff;
         position_in  = '0;
         last_in      = 1'b1;
         rejected_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sil_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      slot_ff     <= slot_in;
      idx_ff      <= idx_in;
      element_ff  <= element_in;
      position_ff <= position_in;
      last_ff     <= last_in;
      rejected_ff <= rejected_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.element     = element_ff;
   assign rsp.position    = position_ff;
   assign rsp.last_of_run = last_ff;
   assign rsp.rejected    = rejected_ff;

endmodule

/* hdl/sorted_insert_list_core.sv */
// Top level of the sorted insert list core: limit register, sequencer and list store.
// Depends on sil_pkg, sil_req_if, sil_rsp_if, sil_store and sil_seq.
//
//   Channel   Direction  Contents
//   req_chan  in         value (signed 32 bits); -1 clears the list
//   rsp_chan  out        element, position, last_of_run, rejected
//   csr_*     in         capacity_limit (6 bits), write enable plus data
//
// An inserted value is accepted in the idle state; each stored entry greater than it is then
// read and moved up one place, the value is written into its slot, and every entry is
// read back in order, with a read state and a load state for each entry.
// The pace is set by the single read port of the list store and the one shared compare.
// A clear (value -1) produces no result; a rejected value is returned with its flag set.
// Reset empties the list and sets the capacity limit to 32; store contents are not cleared.
// A stalled result channel holds the sequencer in place; a new transaction is accepted
// while the final result of the previous one still waits in the output register.
module sorted_insert_list_core #(
   parameter int unsigned CAPACITY = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   sil_req_if.sink                     req_chan,
   sil_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [sil_pkg::FILL_W-1:0]  csr_wr_data
);

   // The list can never hold more entries than one run of results can report.
   localparam int unsigned DEPTH  = (CAPACITY < sil_pkg::MAX_RESULTS) ?
                                    CAPACITY : sil_pkg::MAX_RESULTS;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [sil_pkg::FILL_W-1:0]        csr_limit_ff, csr_limit_in;
   logic [sil_pkg::FILL_W-1:0]        eff_limit;
   sil_pkg::sil_mem_ctl_type          mem_ctl;
   logic signed [sil_pkg::DATA_W-1:0] rd_data;

   assign csr_limit_in = csr_wr_en ? csr_wr_data : csr_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_limit_ff <= sil_pkg::CAP_LIMIT_RST;
      end else begin
         csr_limit_ff <= csr_limit_in;
      end
   end

   // A limit of zero behaves as one, and a limit above the store depth is cut to the depth.
   always_comb begin
      eff_limit = csr_limit_ff;
      if (csr_limit_ff == '0) begin
         eff_limit = sil_pkg::FILL_W'(1);
      end else if (csr_limit_ff > sil_pkg::FILL_W'(DEPTH)) begin
         eff_limit = sil_pkg::FILL_W'(DEPTH);
      end
   end

   sil_seq #(
      .ADDR_W (ADDR_W)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .limit   (eff_limit),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .mem_ctl (mem_ctl),
      .rd_data (rd_data)
   );

   sil_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_data (rd_data)
   );

endmodule
